// File: src/bctc_pkg.sv
`default_nettype none
package bctc_pkg;

	// cache geometry
	localparam int NUM_SLOTS    = 8;
	localparam int BLOCK_BYTES  = 512;
	localparam int ADDRESS_BITS = 19;

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int OFFS_W = $clog2(BLOCK_BYTES);
	localparam int BLK_W  = ADDRESS_BITS - OFFS_W;
	localparam int LFSR_W = 16;

	localparam int ACTION_W    = 2;
	localparam int KIND_W      = 2;
	localparam int IN_TDATA_W  = ((ADDRESS_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_W = SLOT_W + BLK_W + OFFS_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	// access codes
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NOP   = 2'd3;

	// result codes
	localparam logic [KIND_W-1:0] KIND_HIT       = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITEBACK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FILL      = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DONE      = 2'd3;

	// compare unit answer for the slot under test
	typedef struct packed {
		logic hit;
		logic needs_wb;
	} cmp_res_t;

	// lfsr control from the sequencer
	typedef struct packed {
		logic load;
		logic step;
	} lfsr_ctrl_t;

endpackage
`default_nettype wire

// File: src/bctc_tag_cmp.sv
`default_nettype none
module bctc_tag_cmp import bctc_pkg::*; (
	input  wire logic [BLK_W-1:0] tag,
	input  wire logic             valid,
	input  wire logic             dirty,
	input  wire logic [BLK_W-1:0] key,
	output cmp_res_t              res
);

	// one slot per cycle goes through this compare while the sequencer is not waiting on the output register
	always_comb begin
		res.hit      = valid && (tag == key);
		res.needs_wb = valid && dirty;
	end

endmodule
`default_nettype wire

// File: src/bctc_lfsr.sv
`default_nettype none
module bctc_lfsr import bctc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lfsr_ctrl_t        ctrl,
	input  wire logic [LFSR_W-1:0] seed,
	output logic      [LFSR_W-1:0] cur,
	output logic      [LFSR_W-1:0] nxt
);

	logic [LFSR_W-1:0] lfsr_q;
	logic              fb;

	// fibonacci, taps 16 14 13 11
	always_comb begin
		fb  = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
		nxt = {fb, lfsr_q[LFSR_W-1:1]};
		cur = lfsr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= LFSR_W'(1);
		end else if (ctrl.load) begin
			// zero would lock up the register
			lfsr_q <= (seed == '0) ? LFSR_W'(1) : seed;
		end else if (ctrl.step) begin
			lfsr_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// File: src/block_cache_tag_controller_core.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: action; tdata: byte_address
// m_axis    out  m_axis_tvalid/m_axis_tready    tuser: kind; tdata: slot, block_number,
//                                               byte_offset; tlast: last
// cfg       in   cfg_we (no wait)               cfg_wdata: replacement_seed
//
// one item at a time: s_axis_tready is high only while the sequencer is idle
// the tag compare is one shared unit stepping over slots, one slot per cycle while no
// result waits; a hit stops at its slot, a miss and a flush step over every slot,
// each result also waiting for m_axis_tready; action three is taken and dropped
// reset clears valid and dirty marks and loads the lfsr with 1, tags stay unwritten
// a stalled result holds in the output register and the sequencer waits on it
`default_nettype none
module block_cache_tag_controller_core import bctc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // byte_address, zero pad
	input  wire logic [ACTION_W-1:0]    s_axis_tuser,  // action

	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // slot, block_number, byte_offset, pad
	output logic      [KIND_W-1:0]      m_axis_tuser,  // kind
	output logic                        m_axis_tlast,  // last

	input  wire logic                   cfg_we,
	input  wire logic [LFSR_W-1:0]      cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_VICTIM,
		ST_FILL,
		ST_FLUSH,
		ST_DONE
	} state_t;

	state_t state_q;

	// request being worked on
	logic              is_write_q;
	logic [BLK_W-1:0]  blk_q;
	logic [OFFS_W-1:0] off_q;
	logic [SLOT_W-1:0] idx_q;

	// tag store and per-slot marks
	logic [BLK_W-1:0]     slot_tags_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] slot_valid_q;
	logic [NUM_SLOTS-1:0] slot_dirty_q;

	// output register
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [BLK_W-1:0]  out_blk_q;
	logic [OFFS_W-1:0] out_off_q;
	logic              out_last_q;

	logic              in_fire;
	logic              out_free;
	logic              out_load;
	logic              idx_last;
	logic              tag_wr;
	logic [BLK_W-1:0]  in_blk;
	logic [OFFS_W-1:0] in_off;
	cmp_res_t          cmp;
	lfsr_ctrl_t        lfsr_ctrl;
	logic [LFSR_W-1:0] lfsr_cur;
	logic [LFSR_W-1:0] lfsr_nxt;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign idx_last      = (idx_q == SLOT_W'(NUM_SLOTS - 1));
	assign in_blk        = s_axis_tdata[ADDRESS_BITS-1:OFFS_W];
	assign in_off        = s_axis_tdata[OFFS_W-1:0];

	// a new result enters the output register this cycle
	assign out_load = out_free && (
		((state_q == ST_SEARCH) && cmp.hit) ||
		((state_q == ST_VICTIM) && cmp.needs_wb) ||
		(state_q == ST_FILL) ||
		((state_q == ST_FLUSH) && cmp.needs_wb) ||
		(state_q == ST_DONE));

	// shared compare on the slot the index points at
	bctc_tag_cmp u_cmp (
		.tag   (slot_tags_q[idx_q]),
		.valid (slot_valid_q[idx_q]),
		.dirty (slot_dirty_q[idx_q]),
		.key   (blk_q),
		.res   (cmp)
	);

	// lfsr steps once when the search ends without a hit
	always_comb begin
		lfsr_ctrl.load = cfg_we;
		lfsr_ctrl.step = (state_q == ST_SEARCH) && !cmp.hit && idx_last;
	end

	bctc_lfsr u_lfsr (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lfsr_ctrl),
		.seed   (cfg_wdata),
		.cur    (lfsr_cur),
		.nxt    (lfsr_nxt)
	);

	// new block goes into the victim slot as the fill leaves
	assign tag_wr = (state_q == ST_FILL) && out_free;

	always_ff @(posedge clk) begin
		if (tag_wr) begin
			slot_tags_q[idx_q] <= blk_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_valid_q <= '0;
			slot_dirty_q <= '0;
			out_valid_q  <= 1'b0;
			is_write_q   <= 1'b0;
			idx_q        <= '0;
			blk_q        <= '0;
			off_q        <= '0;
			out_kind_q   <= KIND_HIT;
			out_slot_q   <= '0;
			out_blk_q    <= '0;
			out_off_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						is_write_q <= (s_axis_tuser == ACT_WRITE);
						blk_q      <= in_blk;
						off_q      <= in_off;
						idx_q      <= '0;
						if (s_axis_tuser == ACT_FLUSH) begin
							state_q <= ST_FLUSH;
						end else if (s_axis_tuser != ACT_NOP) begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (cmp.hit) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							out_kind_q  <= KIND_HIT;
							out_slot_q  <= idx_q;
							out_blk_q   <= blk_q;
							out_off_q   <= off_q;
							out_last_q  <= 1'b1;
							if (is_write_q) begin
								slot_dirty_q[idx_q] <= 1'b1;
							end
							state_q <= ST_IDLE;
						end
					end else if (idx_last) begin
						// victim is the stepped value modulo the slot count
						idx_q   <= lfsr_nxt[SLOT_W-1:0];
						state_q <= ST_VICTIM;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end
				ST_VICTIM: begin
					if (!cmp.needs_wb) begin
						state_q <= ST_FILL;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_WRITEBACK;
						out_slot_q  <= idx_q;
						out_blk_q   <= slot_tags_q[idx_q];
						out_off_q   <= '0;
						out_last_q  <= 1'b0;
						state_q     <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_kind_q          <= KIND_FILL;
						out_slot_q          <= idx_q;
						out_blk_q           <= blk_q;
						out_off_q           <= off_q;
						out_last_q          <= 1'b1;
						slot_valid_q[idx_q] <= 1'b1;
						slot_dirty_q[idx_q] <= is_write_q;
						state_q             <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (!cmp.needs_wb || out_free) begin
						if (cmp.needs_wb) begin
							out_valid_q         <= 1'b1;
							out_kind_q          <= KIND_WRITEBACK;
							out_slot_q          <= idx_q;
							out_blk_q           <= slot_tags_q[idx_q];
							out_off_q           <= '0;
							out_last_q          <= 1'b0;
							slot_dirty_q[idx_q] <= 1'b0;
						end
						if (idx_last) begin
							state_q <= ST_DONE;
						end else begin
							idx_q <= idx_q + SLOT_W'(1);
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_DONE;
						out_slot_q  <= '0;
						out_blk_q   <= '0;
						out_off_q   <= '0;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = OUT_TDATA_W'({out_off_q, out_blk_q, out_slot_q});

	// hits and fills close an item, writebacks never do
	a_hit_fill_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_HIT || m_axis_tuser == KIND_FILL)
		|-> m_axis_tlast)
		else $error("hit or fill result without last");

	a_wb_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_WRITEBACK) |-> !m_axis_tlast)
		else $error("writeback result marked last");

	// a filled slot must be valid afterwards
	a_fill_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		tag_wr |=> slot_valid_q[$past(idx_q)])
		else $error("filled slot not valid");

	// the victim lfsr never locks at zero
	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_cur != '0)
		else $error("victim lfsr reached zero");

endmodule
`default_nettype wire

// File: bench/bctc_result_checker.sv
`default_nettype none
module bctc_result_checker import bctc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   s_axis_tvalid,
	input  wire logic                   s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // byte_address, zero pad
	input  wire logic [ACTION_W-1:0]    s_axis_tuser,  // action

	input  wire logic                   m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,  // slot, block_number, byte_offset, pad
	input  wire logic [KIND_W-1:0]      m_axis_tuser,  // kind
	input  wire logic                   m_axis_tlast,  // last

	input  wire logic                   cfg_we,
	input  wire logic [LFSR_W-1:0]      cfg_wdata,

	output int                          outstanding,
	output int                          mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [BLK_W-1:0]  block;
		logic [OFFS_W-1:0] offset;
		logic              last;
	} cache_result_t;

	cache_result_t     results_due[$];
	logic [BLK_W-1:0]  slot_block[NUM_SLOTS];
	logic              slot_present[NUM_SLOTS];
	logic              slot_modified[NUM_SLOTS];
	logic [LFSR_W-1:0] victim_chooser;
	int                fail_count = 0;

	function automatic cache_result_t make_result(input logic [KIND_W-1:0] kind,
			input int slot, input logic [BLK_W-1:0] block,
			input logic [OFFS_W-1:0] offset, input logic last);
		cache_result_t r;
		r.kind   = kind;
		r.slot   = SLOT_W'(slot);
		r.block  = block;
		r.offset = offset;
		r.last   = last;
		return r;
	endfunction

	// tag lookup, dirty tracking and victim choice for one access, or the writebacks of a flush
	task automatic resolve_access(input logic [ACTION_W-1:0] act,
			input logic [ADDRESS_BITS-1:0] addr);
		logic [BLK_W-1:0]  blk;
		logic [OFFS_W-1:0] offs;
		int                hit_slot;
		int                victim;
		blk      = addr[ADDRESS_BITS-1:OFFS_W];
		offs     = addr[OFFS_W-1:0];
		hit_slot = -1;
		case (act)
			ACT_FLUSH: begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (slot_present[i] && slot_modified[i]) begin
						results_due.push_back(make_result(KIND_WRITEBACK, i, slot_block[i],
							'0, 1'b0));
						slot_modified[i] = 1'b0;
					end
				end
				results_due.push_back(make_result(KIND_DONE, 0, '0, '0, 1'b1));
			end
			ACT_READ, ACT_WRITE: begin
				for (int i = 0; i < NUM_SLOTS; i++)
					if (hit_slot < 0 && slot_present[i] && slot_block[i] == blk)
						hit_slot = i;
				if (hit_slot >= 0) begin
					if (act == ACT_WRITE)
						slot_modified[hit_slot] = 1'b1;
					results_due.push_back(make_result(KIND_HIT, hit_slot, blk, offs, 1'b1));
				end else begin
					// fibonacci lfsr, taps 16 14 13 11
					victim_chooser = {victim_chooser[0] ^ victim_chooser[2] ^
						victim_chooser[3] ^ victim_chooser[5], victim_chooser[LFSR_W-1:1]};
					victim = int'(victim_chooser % NUM_SLOTS);
					if (slot_present[victim] && slot_modified[victim])
						results_due.push_back(make_result(KIND_WRITEBACK, victim,
							slot_block[victim], '0, 1'b0));
					slot_block[victim]    = blk;
					slot_present[victim]  = 1'b1;
					slot_modified[victim] = (act == ACT_WRITE);
					results_due.push_back(make_result(KIND_FILL, victim, blk, offs, 1'b1));
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cache_result_t want;
		if (!arst_n) begin
			results_due.delete();
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_block[i]    = '0;
				slot_present[i]  = 1'b0;
				slot_modified[i] = 1'b0;
			end
			victim_chooser = LFSR_W'(1);
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (results_due.size() == 0) begin
					$error("result with none expected: kind %0d, tdata %0h", m_axis_tuser,
						m_axis_tdata);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					check_field("kind", want.kind, m_axis_tuser);
					check_field("slot", want.slot, m_axis_tdata[SLOT_W-1:0]);
					check_field("block_number", want.block, m_axis_tdata[SLOT_W +: BLK_W]);
					check_field("byte_offset", want.offset,
						m_axis_tdata[SLOT_W+BLK_W +: OFFS_W]);
					check_field("last", want.last, m_axis_tlast);
				end
			end
			// a zero seed would lock the lfsr
			if (cfg_we)
				victim_chooser = (cfg_wdata == '0) ? LFSR_W'(1) : cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				resolve_access(s_axis_tuser, s_axis_tdata[ADDRESS_BITS-1:0]);
			outstanding <= results_due.size();
		end
		mismatches <= fail_count;
	end

endmodule
`default_nettype wire

// File: bench/tb_block_cache_tag_controller_core.sv
`default_nettype none
module tb_block_cache_tag_controller_core import bctc_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// random part: five phases with their own seed and idling mix
	localparam int PHASES        = 5;
	localparam int PHASE_ITEMS   = 62;
	localparam int HOT_BLOCKS    = 12;                 // a few more than slots, so evictions happen
	localparam int SETTLE_CYCLES = 2 * NUM_SLOTS + 8;  // covers a dropped action three in flight
	localparam int STALL_LIMIT   = 2000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // byte_address, zero pad
	logic [ACTION_W-1:0]    s_axis_tuser = ACT_READ;  // action

	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b1;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // slot, block_number, byte_offset, pad
	logic [KIND_W-1:0]      m_axis_tuser;        // kind
	logic                   m_axis_tlast;        // last

	logic                   cfg_we = 1'b0;
	logic [LFSR_W-1:0]      cfg_wdata = '0;

	int                     outstanding;
	int                     mismatches;

	// idling switches, changed per phase
	logic                   sender_idles = 1'b1;
	logic                   receiver_idles = 1'b1;
	int                     ready_hold = 0;

	// working set of blocks so that most accesses hit
	logic [BLK_W-1:0]       hot_block[HOT_BLOCKS];

	always #2 clk = ~clk;

	block_cache_tag_controller_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	bctc_result_checker cache_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.outstanding   (outstanding),
		.mismatches    (mismatches)
	);

	// result backpressure: random low bursts when enabled
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			ready_hold    <= $urandom_range(0, 2);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// ends the run if neither channel nor the register port moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	// offer one access and hold it until taken, then maybe leave a gap;
	// without a gap tvalid simply stays high into the next item
	task automatic send_item(input logic [ACTION_W-1:0] act,
			input logic [ADDRESS_BITS-1:0] addr);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= IN_TDATA_W'(addr);
		do @(posedge clk); while (!s_axis_tready);
		if (sender_idles && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// stop offering, wait for every result, then let a dropped item pass through
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_seed(input logic [LFSR_W-1:0] seed);
		cfg_we    <= 1'b1;
		cfg_wdata <= seed;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly the working set, now and then anywhere in the address space
	function automatic logic [ADDRESS_BITS-1:0] pick_address();
		logic [OFFS_W-1:0] offs;
		offs = OFFS_W'($urandom_range(0, BLOCK_BYTES - 1));
		if ($urandom_range(0, 9) == 0)
			return ADDRESS_BITS'($urandom);
		return {hot_block[$urandom_range(0, HOT_BLOCKS - 1)], offs};
	endfunction

	function automatic logic [ACTION_W-1:0] pick_action();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return ACT_READ;
		if (r < 85)
			return ACT_WRITE;
		if (r < 93)
			return ACT_FLUSH;
		return ACT_NOP;
	endfunction

	initial begin : stimulus
		logic [LFSR_W-1:0] seed;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset seed of one
		send_item(ACT_READ, '0);                        // cold miss, fill
		send_item(ACT_READ, '0);                        // hit at offset zero
		send_item(ACT_WRITE, ADDRESS_BITS'(BLOCK_BYTES - 1));  // write hit, top offset
		send_item(ACT_WRITE, '1);                       // write miss, highest block and offset
		send_item(ACT_READ, {{BLK_W{1'b1}}, {OFFS_W{1'b0}}});  // hit on the dirty fill
		send_item(ACT_NOP, ADDRESS_BITS'('h55555));     // action three, dropped
		send_item(ACT_FLUSH, '0);                       // writes back the one dirty slot
		send_item(ACT_FLUSH, '1);                       // nothing dirty, done alone
		// more distinct blocks than slots: dirty victims get written back
		for (int k = 0; k < 10; k++)
			send_item(ACT_WRITE, {BLK_W'(k * 37 + 5), OFFS_W'(k)});
		send_item(ACT_READ, ADDRESS_BITS'('h55555));
		send_item(ACT_WRITE, ADDRESS_BITS'('h2AAAA));
		send_item(ACT_NOP, '1);
		send_item(ACT_FLUSH, ADDRESS_BITS'('h2AAAA));

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       seed = '0;            // zero seed, loads one instead
				1:       seed = '1;
				2:       seed = LFSR_W'($urandom_range(1, 65535));
				3:       seed = LFSR_W'(1) << (LFSR_W - 1);
				default: seed = LFSR_W'(1);
			endcase
			drain();
			load_seed(seed);

			// idling mix: both, results only, items only, both, then none at the end
			sender_idles   <= (phase == 0 || phase == 2 || phase == 3);
			receiver_idles <= (phase == 0 || phase == 1 || phase == 3);
			for (int i = 0; i < HOT_BLOCKS; i++)
				hot_block[i] = BLK_W'($urandom);

			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item(pick_action(), pick_address());
		end

		drain();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
